FILE: src/u32bd_pkg.sv
// ----------------------------------------------------------------------------
// u32bd_pkg: shared types and constants for the UTF-32 byte decoder
// Byte order codes, byte order marks and the result beat layout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package u32bd_pkg;

  typedef logic [1:0] order_t;

  localparam order_t ORDER_BIG    = 2'd0;
  localparam order_t ORDER_LITTLE = 2'd1;
  localparam order_t ORDER_DETECT = 2'd2;
  localparam order_t ORDER_UNDEF  = 2'd3;

  localparam logic [31:0] MARK_BIG    = 32'h0000_feff;
  localparam logic [31:0] MARK_LITTLE = 32'hfffe_0000;

  typedef struct packed {
    logic        code_valid;
    logic [31:0] code_point;
    logic        status;
    order_t      byte_order_now;
  } result_t;

endpackage

FILE: src/utf32_byte_decoder_top.sv
// ----------------------------------------------------------------------------
// utf32_byte_decoder_top: UTF-32 byte decoder with byte order mark detection
// Result beats are registered; one byte accepted per cycle while in_stall is low.
// The rate is set by one decode pass between the word state and the result
// register; a skid register keeps input flowing for one stalled result beat.
// Synchronous active-low reset: detect order, empty word, no beats held.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf32_byte_decoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_code_valid,
  output logic [31:0] out_code_point,
  output logic        out_status,
  output logic [1:0]  out_byte_order_now
);

  logic [31:0]       partial_r, partial_nxt;
  logic [1:0]        idx_r, idx_nxt;
  u32bd_pkg::order_t order_r, order_nxt;
  logic              emitted_r, emitted_nxt;

  u32bd_pkg::result_t res;
  u32bd_pkg::result_t out_r;
  u32bd_pkg::result_t skid_r;
  logic               out_vld_r;
  logic               skid_vld_r;

  logic        in_acc;
  logic        out_free;
  logic [31:0] w_big;
  logic [31:0] w_lit;
  logic        is_mark;

  assign in_stall = skid_vld_r;
  assign in_acc   = in_valid && !skid_vld_r;
  assign out_free = !out_vld_r || !out_stall;

  assign w_big = {partial_r[23:0], in_byte};

  always_comb begin
    unique case (idx_r)
      2'd0: w_lit = {partial_r[31:8], in_byte};
      2'd1: w_lit = {partial_r[31:16], in_byte, partial_r[7:0]};
      2'd2: w_lit = {partial_r[31:24], in_byte, partial_r[15:0]};
      2'd3: w_lit = {in_byte, partial_r[23:0]};
      default: w_lit = partial_r;
    endcase
  end

  // Decode one byte against the current word state
  always_comb begin
    partial_nxt = partial_r;
    idx_nxt     = idx_r;
    order_nxt   = order_r;
    emitted_nxt = emitted_r;
    res.code_valid = 1'b0;
    res.code_point = 32'd0;
    res.status     = 1'b0;
    is_mark        = 1'b0;
    unique case (order_r)
      u32bd_pkg::ORDER_DETECT: begin
        if (emitted_r) begin
          res.status = 1'b1;
        end else if (idx_r == 2'd3) begin
          if (w_big == u32bd_pkg::MARK_BIG) begin
            order_nxt = u32bd_pkg::ORDER_BIG;
          end else if (w_big == u32bd_pkg::MARK_LITTLE) begin
            order_nxt = u32bd_pkg::ORDER_LITTLE;
          end else begin
            res.status = 1'b1;
          end
          partial_nxt = 32'd0;
          idx_nxt     = 2'd0;
        end else begin
          partial_nxt = w_big;
          idx_nxt     = idx_r + 2'd1;
        end
      end
      u32bd_pkg::ORDER_BIG, u32bd_pkg::ORDER_LITTLE: begin
        partial_nxt = (order_r == u32bd_pkg::ORDER_BIG) ? w_big : w_lit;
        if (idx_r == 2'd3) begin
          is_mark = (partial_nxt == u32bd_pkg::MARK_BIG) ||
                    (partial_nxt == u32bd_pkg::MARK_LITTLE);
          // drop a misplaced mark
          if (is_mark) begin
            res.status = 1'b1;
          end else begin
            res.code_valid = 1'b1;
            res.code_point = partial_nxt;
            emitted_nxt    = 1'b1;
          end
          partial_nxt = 32'd0;
          idx_nxt     = 2'd0;
        end else begin
          idx_nxt = idx_r + 2'd1;
        end
      end
      u32bd_pkg::ORDER_UNDEF: begin
        res.status = 1'b1;
      end
      default: begin
        res.status = 1'b1;
      end
    endcase
    res.byte_order_now = order_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= 32'd0;
      idx_r     <= 2'd0;
      order_r   <= u32bd_pkg::ORDER_DETECT;
      emitted_r <= 1'b0;
    end else if (cfg_we) begin
      partial_r <= 32'd0;
      idx_r     <= 2'd0;
      order_r   <= cfg_wdata;
    end else if (in_acc) begin
      partial_r <= partial_nxt;
      idx_r     <= idx_nxt;
      order_r   <= order_nxt;
      emitted_r <= emitted_nxt;
    end
  end

  // Result register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (out_free) begin
        out_r      <= skid_r;
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end
    end else if (in_acc) begin
      if (out_free) begin
        out_r     <= res;
        out_vld_r <= 1'b1;
      end else begin
        // hold the new beat until the result register drains
        skid_r     <= res;
        skid_vld_r <= 1'b1;
      end
    end else if (out_free) begin
      out_vld_r <= 1'b0;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_code_valid     = out_r.code_valid;
  assign out_code_point     = out_r.code_point;
  assign out_status         = out_r.status;
  assign out_byte_order_now = out_r.byte_order_now;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid entry held with empty result register");

  a_code_no_error: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.code_valid) |-> !out_r.status)
    else $error("code point beat flagged as error");

  a_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_r.code_valid) |-> (out_r.code_point == 32'd0))
    else $error("non-zero code point without code_valid");

  a_undef_idle_word: assert property (@(posedge clk) disable iff (!rst_n)
    (order_r == u32bd_pkg::ORDER_UNDEF) |-> (idx_r == 2'd0))
    else $error("word gathered in undefined order");

  a_locked_detect_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (order_r == u32bd_pkg::ORDER_DETECT && emitted_r) |-> (idx_r == 2'd0))
    else $error("word gathered in detect order after output");
`endif

endmodule

FILE: dv/tb_utf32_byte_decoder_top.sv
// ----------------------------------------------------------------------------
// tb_utf32_byte_decoder_top: testbench for the UTF-32 byte decoder
// Drives bytes over valid/stall, predicts every result beat from a model of
// the word assembly and mark detection, and checks each beat field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_utf32_byte_decoder_top;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 64;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_wdata = 2'b00;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_code_valid;
  logic [31:0] out_code_point;
  logic        out_status;
  logic [1:0]  out_byte_order_now;

  utf32_byte_decoder_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_byte            (in_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_code_valid     (out_code_valid),
    .out_code_point     (out_code_point),
    .out_status         (out_status),
    .out_byte_order_now (out_byte_order_now)
  );

  always #4 clk = ~clk;

  // Decoder state as predicted
  u32bd_pkg::order_t pred_order   = u32bd_pkg::ORDER_DETECT;
  logic [31:0]       pred_word    = '0;
  logic [1:0]        pred_index   = '0;
  logic              pred_emitted = 1'b0;

  u32bd_pkg::result_t pending_codes[$];
  u32bd_pkg::result_t want;
  int      mismatches = 0;
  int      sender_idle_pct = 0;
  int      stall_pct = 0;
  int      hold_req = 0;
  int      hold_seen = 0;
  int      hold_left = 0;
  int      quiet_cycles = 0;

  function automatic u32bd_pkg::result_t decode_byte(input logic [7:0] b);
    u32bd_pkg::result_t r;
    logic [31:0]        w;
    r = '0;
    if (pred_order == u32bd_pkg::ORDER_DETECT) begin
      if (pred_emitted) begin
        r.status = 1'b1;
      end else begin
        w = {pred_word[23:0], b};
        if (pred_index == 2'd3) begin
          if (w == u32bd_pkg::MARK_BIG) pred_order = u32bd_pkg::ORDER_BIG;
          else if (w == u32bd_pkg::MARK_LITTLE) pred_order = u32bd_pkg::ORDER_LITTLE;
          else r.status = 1'b1;
          pred_word  = '0;
          pred_index = '0;
        end else begin
          pred_word  = w;
          pred_index = pred_index + 2'd1;
        end
      end
    end else if (pred_order == u32bd_pkg::ORDER_BIG ||
                 pred_order == u32bd_pkg::ORDER_LITTLE) begin
      if (pred_order == u32bd_pkg::ORDER_BIG) w = {pred_word[23:0], b};
      else w = pred_word | ({24'b0, b} << (8 * pred_index));
      if (pred_index == 2'd3) begin
        if (w == u32bd_pkg::MARK_BIG || w == u32bd_pkg::MARK_LITTLE) begin
          r.status = 1'b1;
        end else begin
          r.code_valid = 1'b1;
          r.code_point = w;
          pred_emitted = 1'b1;
        end
        pred_word  = '0;
        pred_index = '0;
      end else begin
        pred_word  = w;
        pred_index = pred_index + 2'd1;
      end
    end else begin
      r.status = 1'b1;
    end
    r.byte_order_now = pred_order;
    return r;
  endfunction

  // Called and returns at a falling edge
  task automatic send_byte(input logic [7:0] b);
    if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_codes.push_back(decode_byte(b));
    @(negedge clk);
  endtask

  task automatic send_bytes(input logic [31:0] w, input int n);
    for (int i = 0; i < n; i++) send_byte(w[31 - 8 * i -: 8]);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_codes.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic set_byte_order(input u32bd_pkg::order_t v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    pred_order = v;
    pred_word  = '0;
    pred_index = '0;
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(9))
      0:       return u32bd_pkg::MARK_BIG;
      1:       return u32bd_pkg::MARK_LITTLE;
      2:       return $urandom;
      3:       return $urandom_range(1) ? 32'hffff_ffff : 32'h0000_0000;
      default: return $urandom_range(32'h0010_ffff);
    endcase
  endfunction

  // Mostly whole words in the order in force, now and then a stray byte
  task automatic send_random_stream(input int n_items);
    int          sent;
    logic [31:0] w;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(19) == 0) begin
        send_byte(8'($urandom_range(255)));
        sent++;
      end else begin
        w = pick_word();
        for (int i = 0; i < 4; i++) begin
          if (pred_order == u32bd_pkg::ORDER_LITTLE) send_byte(w[8 * i +: 8]);
          else send_byte(w[31 - 8 * i -: 8]);
        end
        sent += 4;
      end
    end
  endtask

  task automatic test_mark_detect();
    send_bytes(32'h1234_5678, 4);
    send_bytes(u32bd_pkg::MARK_BIG, 4);
    set_byte_order(u32bd_pkg::ORDER_DETECT);
    send_bytes(u32bd_pkg::MARK_LITTLE, 4);
  endtask

  task automatic test_endian_words();
    send_bytes(32'h7856_3412, 4);
    send_bytes(u32bd_pkg::MARK_LITTLE, 4);
    set_byte_order(u32bd_pkg::ORDER_BIG);
    send_bytes(32'hffff_ffff, 4);
    send_bytes(32'h0000_0000, 4);
    send_bytes(u32bd_pkg::MARK_BIG, 4);
  endtask

  task automatic test_order_reload();
    send_bytes(32'habcd_0000, 2);
    set_byte_order(u32bd_pkg::ORDER_DETECT);
    send_byte(8'h00);
    set_byte_order(u32bd_pkg::ORDER_UNDEF);
    send_byte(8'hff);
    set_byte_order(u32bd_pkg::ORDER_LITTLE);
    send_bytes(32'h0100_0000, 4);
  endtask

  task automatic test_random_phases();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  stall_pct = 0;  end
        1: begin sender_idle_pct = 73; stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  stall_pct = 73; end
        default: begin sender_idle_pct = 15; stall_pct = 15; end
      endcase
      set_byte_order(phase[0] ? u32bd_pkg::ORDER_LITTLE : u32bd_pkg::ORDER_BIG);
      send_random_stream(64);
      set_byte_order(phase[0] ? u32bd_pkg::ORDER_BIG : u32bd_pkg::ORDER_LITTLE);
      send_random_stream(64);
      set_byte_order(phase[0] ? u32bd_pkg::ORDER_UNDEF : u32bd_pkg::ORDER_DETECT);
      send_random_stream(8);
    end
    sender_idle_pct = 0;
    stall_pct = 0;
  endtask

  task automatic test_backpressure();
    set_byte_order(u32bd_pkg::ORDER_BIG);
    hold_req++;
    send_random_stream(24);
    stall_pct = 30;
    send_random_stream(40);
    stall_pct = 0;
  endtask

  task automatic test_drain_pause();
    set_byte_order(u32bd_pkg::ORDER_LITTLE);
    sender_idle_pct = 30;
    send_random_stream(16);
    in_valid <= 1'b0;
    while (pending_codes.size() != 0) @(negedge clk);
    @(negedge clk);
    send_random_stream(16);
    sender_idle_pct = 0;
  endtask

  // Receiver stall: long hold when requested, else random
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_codes.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result beat: valid=%0b code=%08h status=%0b order=%0d",
                   out_code_valid, out_code_point, out_status, out_byte_order_now);
        mismatches++;
      end else begin
        want = pending_codes.pop_front();
        if (out_code_valid !== want.code_valid || out_code_point !== want.code_point ||
            out_status !== want.status || out_byte_order_now !== want.byte_order_now) begin
          if (mismatches < 10)
            $display("mismatch: exp %0b/%08h/%0b/%0d got %0b/%08h/%0b/%0d",
                     want.code_valid, want.code_point, want.status, want.byte_order_now,
                     out_code_valid, out_code_point, out_status, out_byte_order_now);
          mismatches++;
        end
      end
    end
  end

  // Abort when neither channel moves a beat for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_mark_detect();
    test_endian_words();
    test_order_reload();
    test_random_phases();
    test_backpressure();
    test_drain_pause();
    in_valid <= 1'b0;
    while (pending_codes.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
    if (pending_codes.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/u32bd_pkg.sv
src/utf32_byte_decoder_top.sv
dv/tb_utf32_byte_decoder_top.sv
